// ===== sv/readahead_window_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Readahead window controller assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef READAHEAD_WINDOW_CONTROLLER_ASSERT_SVH
`define READAHEAD_WINDOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on the clock, off during reset.
`define RWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the clock, off during reset.
`define RWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Readahead window controller package
// Field widths, request and outcome codes, size thresholds and shared types.
// ----------------------------------------------------------------------------
package rwc_pkg;

    // Field widths.
    localparam int TYPE_W  = 2;
    localparam int LUN_W   = 2;
    localparam int SEC_W   = 32;
    localparam int BYTES_W = 21;
    localparam int COPY_W  = 20;
    localparam int ADDR_W  = 42;
    localparam int WS_W    = 34;

    // Request type codes.
    localparam logic [TYPE_W-1:0] REQ_READ      = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FILL_DONE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_FILL_FAIL = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_ATTACH    = 2'd3;

    // Outcome codes.
    localparam logic [1:0] OUT_HIT    = 2'd0;
    localparam logic [1:0] OUT_MISS   = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;
    localparam logic [1:0] OUT_ACK    = 2'd3;

    // Request size thresholds.
    localparam logic [BYTES_W-1:0] SIZE_512  = 21'd512;
    localparam logic [BYTES_W-1:0] SIZE_8K   = 21'd8192;
    localparam logic [BYTES_W-1:0] SIZE_16K  = 21'd16384;
    localparam logic [BYTES_W-1:0] SIZE_32K  = 21'd32768;
    localparam logic [BYTES_W-1:0] SIZE_64K  = 21'd65536;
    localparam logic [BYTES_W-1:0] SIZE_128K = 21'd131072;

    // Prefetch base sizes before the factor is applied.
    localparam longint PF_BASE_XL = 256 * 1024;
    localparam longint PF_BASE_L  = 128 * 1024;
    localparam longint PF_BASE_M  = 64 * 1024;
    localparam longint PF_BASE_S  = 16 * 1024;

    // One readahead window.
    typedef struct packed {
        logic [WS_W-1:0]    ws;
        logic [BYTES_W-1:0] wb;
        logic [BYTES_W-1:0] rp;
    } t_window;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [BYTES_W-1:0] dividend;
        logic [BYTES_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [BYTES_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/rwc_divider.sv =====
// ----------------------------------------------------------------------------
// Readahead window controller divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwc_pkg::t_div_req i_req,
    output rwc_pkg::t_div_rsp o_rsp
);

    localparam int W     = rwc_pkg::BYTES_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [W:0]       w_shift;
    logic [W:0]       w_trial;

    // Shift in the next dividend bit and try the subtraction.
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    // Iteration counter and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_rem <= w_trial[W] ? w_shift[W-1:0] : w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], ~w_trial[W]};
                r_cnt <= r_cnt - CNT_W'(1);
            end else if (i_req.start) begin
                r_rem <= '0;
                r_quo <= i_req.dividend;
                r_den <= i_req.divisor;
                r_cnt <= CNT_W'(W);
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/rwc_window_store.sv =====
// ----------------------------------------------------------------------------
// Readahead window controller window store
// Per-unit window registers, cleared by reset, one read and one write port.
// ----------------------------------------------------------------------------
module rwc_window_store #(
    parameter int DEPTH = 4,
    parameter int IDX_W = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output rwc_pkg::t_window o_rd_win,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  rwc_pkg::t_window i_wr_win
);

    rwc_pkg::t_window r_win [DEPTH];

    // Reset empties every window; a write replaces one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_win[i_wr_idx] <= i_wr_win;
        end
    end

    assign o_rd_win = r_win[i_rd_idx];

endmodule

// ===== sv/readahead_window_controller.sv =====
// An event or a rejected read goes from accept through LOAD to FINISH, a
// miss also through WSECS, RANGE and HIT, and a hit also through COUNT, where
// the 21-step serial divider runs once for the count of requests left in the
// window. No new item is taken while busy, and a stalled result holds the
// block in its last step.
// Reset (synchronous, active low) empties all windows and drops output valid.
// ----------------------------------------------------------------------------
// Readahead window controller
// Per-unit readahead window: hit check, window consume and prefetch decision,
// sequenced over one shared divider.
// ----------------------------------------------------------------------------
module readahead_window_controller #(
    parameter int LUN_COUNT       = 4,
    parameter int BUFFER_BYTES    = 1048576,
    parameter int PREFETCH_FACTOR = 4,
    parameter int SECTOR_BYTES    = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rwc_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [rwc_pkg::LUN_W-1:0]     i_lun,
    input  logic [rwc_pkg::SEC_W-1:0]     i_start_sector,
    input  logic [rwc_pkg::BYTES_W-1:0]   i_request_bytes,
    input  logic [rwc_pkg::BYTES_W-1:0]   i_fill_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_outcome,
    output logic [rwc_pkg::COPY_W-1:0]    o_copy_position,
    output logic                          o_prefetch_issue,
    output logic [rwc_pkg::ADDR_W-1:0]    o_prefetch_byte_address,
    output logic [rwc_pkg::BYTES_W-1:0]   o_prefetch_bytes
);

    localparam int BYTES_W = rwc_pkg::BYTES_W;
    localparam int SEC_W   = rwc_pkg::SEC_W;
    localparam int WS_W    = rwc_pkg::WS_W;
    localparam int ADDR_W  = rwc_pkg::ADDR_W;
    localparam int COPY_W  = rwc_pkg::COPY_W;

    // Window store geometry: only units the lun field can name are kept.
    localparam int LUN_SPAN    = 1 << rwc_pkg::LUN_W;
    localparam int STORE_DEPTH = (LUN_COUNT < LUN_SPAN) ? LUN_COUNT : LUN_SPAN;
    localparam int STORE_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Sector size constants.
    localparam int                 SB_W   = $clog2(SECTOR_BYTES + 1);
    localparam logic [SB_W-1:0]    SB_MUL = SB_W'(SECTOR_BYTES);

    // Byte count to whole sectors by reciprocal multiplication, exact for
    // every value of the byte field.
    localparam int                 SB_L    = $clog2(SECTOR_BYTES);
    localparam int                 RCP_SH  = BYTES_W + SB_L;
    localparam int                 RCP_W   = BYTES_W + 1;
    localparam int                 PROD_W  = BYTES_W + RCP_W;
    localparam longint             RCP_M   = ((longint'(1) << RCP_SH)
                                             + longint'(SECTOR_BYTES) - 1)
                                             / longint'(SECTOR_BYTES);
    localparam logic [RCP_W-1:0]   RCP_MUL = RCP_W'(RCP_M);

    // Fill clamp limit.
    localparam int               BUF_W     = $clog2(BUFFER_BYTES + 1);
    localparam int               CMP_W     = (BUF_W > BYTES_W) ? BUF_W : BYTES_W;
    localparam logic [CMP_W-1:0] BUF_LIMIT = CMP_W'(BUFFER_BYTES);

    // Prefetch sizes, saturated at the buffer size.
    localparam longint PF_RAW_XL = rwc_pkg::PF_BASE_XL * PREFETCH_FACTOR;
    localparam longint PF_RAW_L  = rwc_pkg::PF_BASE_L * PREFETCH_FACTOR;
    localparam longint PF_RAW_M  = rwc_pkg::PF_BASE_M * PREFETCH_FACTOR;
    localparam longint PF_RAW_S  = rwc_pkg::PF_BASE_S * PREFETCH_FACTOR;
    localparam longint PF_SAT_XL = (PF_RAW_XL > BUFFER_BYTES) ? BUFFER_BYTES : PF_RAW_XL;
    localparam longint PF_SAT_L  = (PF_RAW_L > BUFFER_BYTES) ? BUFFER_BYTES : PF_RAW_L;
    localparam longint PF_SAT_M  = (PF_RAW_M > BUFFER_BYTES) ? BUFFER_BYTES : PF_RAW_M;
    localparam longint PF_SAT_S  = (PF_RAW_S > BUFFER_BYTES) ? BUFFER_BYTES : PF_RAW_S;
    localparam logic [BYTES_W-1:0] PF_SIZE_XL = BYTES_W'(PF_SAT_XL);
    localparam logic [BYTES_W-1:0] PF_SIZE_L  = BYTES_W'(PF_SAT_L);
    localparam logic [BYTES_W-1:0] PF_SIZE_M  = BYTES_W'(PF_SAT_M);
    localparam logic [BYTES_W-1:0] PF_SIZE_S  = BYTES_W'(PF_SAT_S);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WSECS,
        S_RANGE,
        S_HIT,
        S_COUNT,
        S_FINISH
    } t_state;

    t_state r_state;

    // Captured item.
    logic [rwc_pkg::TYPE_W-1:0] r_req_type;
    logic [rwc_pkg::LUN_W-1:0]  r_lun;
    logic [SEC_W-1:0]           r_sec;
    logic [BYTES_W-1:0]         r_req;
    logic [BYTES_W-1:0]         r_fill;

    // Working registers.
    logic [WS_W-1:0]    r_ws;
    logic [BYTES_W-1:0] r_wb;
    logic [BYTES_W-1:0] r_rp;
    logic [BYTES_W-1:0] r_wsecs;
    logic [BYTES_W-1:0] r_req_secs;
    logic               r_in_range;
    logic [BYTES_W-1:0] r_offs;
    logic [ADDR_W-1:0]  r_addr_prod;
    logic               r_hit;
    logic [BYTES_W-1:0] r_rest;
    logic [BYTES_W-1:0] r_cnt;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_out_outcome;
    logic [COPY_W-1:0]  r_out_copy;
    logic               r_out_issue;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [BYTES_W-1:0] r_out_plen;

    // Next output values.
    logic [1:0]         n_outcome;
    logic [COPY_W-1:0]  n_copy;
    logic               n_issue;
    logic [ADDR_W-1:0]  n_addr;
    logic [BYTES_W-1:0] n_plen;
    rwc_pkg::t_window   n_win;

    rwc_pkg::t_window  w_rd_win;
    rwc_pkg::t_div_req w_div_req;
    rwc_pkg::t_div_rsp w_div_rsp;

    logic                    w_lun_ok;
    logic                    w_is_event;
    logic                    w_reject;
    logic                    w_slot_free;
    logic                    w_win_write;
    logic [WS_W-1:0]         w_sec_ext;
    logic [WS_W:0]           w_win_end;
    logic                    w_in_range;
    logic [WS_W-1:0]         w_sec_diff;
    logic [BYTES_W+SB_W-1:0] w_offs_prod;
    logic [SEC_W+SB_W-1:0]   w_addr_prod;
    logic [BYTES_W-1:0]      w_avail;
    logic                    w_hit;
    logic [BYTES_W-1:0]      w_rest;
    logic                    w_cnt_issue;
    logic [CMP_W-1:0]        w_fill_ext;
    logic [BYTES_W-1:0]      w_fill_clamp;
    logic [WS_W-1:0]         w_ws_next;
    logic [BYTES_W-1:0]      w_rp_next;

    // Whole sectors in a byte count.
    function automatic logic [BYTES_W-1:0] sectors_of(input logic [BYTES_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RCP_MUL);
        return BYTES_W'(p[PROD_W-1:RCP_SH]);
    endfunction

    // Item classification.
    assign w_lun_ok    = (32'(r_lun) < 32'(LUN_COUNT));
    assign w_is_event  = (r_req_type != rwc_pkg::REQ_READ);
    assign w_reject    = !w_is_event && ((r_req == '0) || !w_lun_ok);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Window range check and offset of the request inside the window.
    assign w_sec_ext   = {{(WS_W - SEC_W){1'b0}}, r_sec};
    assign w_win_end   = {1'b0, r_ws} + {{(WS_W + 1 - BYTES_W){1'b0}}, r_wsecs};
    assign w_in_range  = (r_wb != '0) && (w_sec_ext >= r_ws)
                         && ({1'b0, w_sec_ext} <= w_win_end);
    assign w_sec_diff  = w_sec_ext - r_ws;
    assign w_offs_prod = w_sec_diff[BYTES_W-1:0] * SB_MUL;

    // Hit test and bytes left after the consume.
    assign w_avail     = r_wb - r_offs;
    assign w_hit       = r_in_range && (r_offs <= r_wb) && (w_avail >= r_req);
    assign w_rest      = w_avail - r_req;
    assign w_addr_prod = r_sec * SB_MUL;

    // Fill length clamped to the buffer.
    assign w_fill_ext   = CMP_W'(r_fill);
    assign w_fill_clamp = (w_fill_ext > BUF_LIMIT) ? BUF_LIMIT[BYTES_W-1:0] : r_fill;

    // Window advance for a read.
    assign w_ws_next = w_sec_ext + {{(WS_W - BYTES_W){1'b0}}, r_req_secs};
    assign w_rp_next = r_rp + r_offs + r_req;

    // Prefetch trigger on a hit from the count of whole requests left.
    assign w_cnt_issue = (r_cnt == '0)
        || (((r_req == rwc_pkg::SIZE_64K) || (r_req == rwc_pkg::SIZE_32K))
            && (r_cnt < BYTES_W'(2)))
        || ((r_req <= rwc_pkg::SIZE_16K) && (r_req > rwc_pkg::SIZE_512)
            && (r_cnt < BYTES_W'(4)))
        || ((r_req == rwc_pkg::SIZE_512) && (r_cnt < BYTES_W'(8)));

    // Divider request: whole requests left in the window after a hit.
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            S_HIT: begin
                if (w_hit) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = w_rest;
                    w_div_req.divisor  = r_req;
                end
            end
            default: begin
            end
        endcase
    end

    // Result and window update for the item in hand.
    always_comb begin
        n_outcome   = rwc_pkg::OUT_ACK;
        n_copy      = '0;
        n_issue     = 1'b0;
        n_addr      = '0;
        n_plen      = '0;
        n_win       = '0;
        w_win_write = 1'b0;
        if (w_is_event) begin
            w_win_write = w_lun_ok;
            case (r_req_type)
                rwc_pkg::REQ_FILL_DONE: begin
                    n_win.ws = r_ws;
                    n_win.wb = w_fill_clamp;
                    n_win.rp = r_rp;
                end
                rwc_pkg::REQ_ATTACH: begin
                    n_win.wb = w_fill_clamp;
                end
                default: begin
                end
            endcase
        end else if (w_reject) begin
            n_outcome = rwc_pkg::OUT_REJECT;
        end else begin
            w_win_write = 1'b1;
            n_issue     = !r_hit || w_cnt_issue;
            n_win.ws    = w_ws_next;
            if (r_hit) begin
                n_outcome = rwc_pkg::OUT_HIT;
                n_copy    = r_rp[COPY_W-1:0] + r_offs[COPY_W-1:0];
                n_win.wb  = r_rest;
                n_win.rp  = w_rp_next;
            end else begin
                n_outcome = rwc_pkg::OUT_MISS;
            end
            if (n_issue) begin
                n_addr   = r_addr_prod + {{(ADDR_W - BYTES_W){1'b0}}, r_req};
                n_win.wb = '0;
                n_win.rp = '0;
                if (r_req >= rwc_pkg::SIZE_128K) begin
                    n_plen = PF_SIZE_XL;
                end else if (r_req >= rwc_pkg::SIZE_32K) begin
                    n_plen = PF_SIZE_L;
                end else if (r_req >= rwc_pkg::SIZE_8K) begin
                    n_plen = PF_SIZE_M;
                end else begin
                    n_plen = PF_SIZE_S;
                end
            end
        end
    end

    // Sequencer, working registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req_type <= i_req_type;
                        r_lun      <= i_lun;
                        r_sec      <= i_start_sector;
                        r_req      <= i_request_bytes;
                        r_fill     <= i_fill_bytes;
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ws <= w_rd_win.ws;
                    r_wb <= w_rd_win.wb;
                    r_rp <= w_rd_win.rp;
                    if (w_is_event || w_reject) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_WSECS;
                    end
                end
                S_WSECS: begin
                    r_wsecs    <= sectors_of(r_wb);
                    r_req_secs <= sectors_of(r_req);
                    r_state    <= S_RANGE;
                end
                S_RANGE: begin
                    r_in_range <= w_in_range;
                    r_offs     <= w_offs_prod[BYTES_W-1:0];
                    r_state    <= S_HIT;
                end
                S_HIT: begin
                    r_hit       <= w_hit;
                    r_rest      <= w_rest;
                    r_addr_prod <= w_addr_prod[ADDR_W-1:0];
                    r_state     <= w_hit ? S_COUNT : S_FINISH;
                end
                S_COUNT: begin
                    if (w_div_rsp.done) begin
                        r_cnt   <= w_div_rsp.quotient;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_outcome <= n_outcome;
                        r_out_copy    <= n_copy;
                        r_out_issue   <= n_issue;
                        r_out_addr    <= n_addr;
                        r_out_plen    <= n_plen;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Shared divider.
    rwc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Per-unit windows.
    rwc_window_store #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (STORE_IDX_W)
    ) u_window_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_lun[STORE_IDX_W-1:0]),
        .o_rd_win (w_rd_win),
        .i_wr_en  ((r_state == S_FINISH) && w_slot_free && w_win_write),
        .i_wr_idx (r_lun[STORE_IDX_W-1:0]),
        .i_wr_win (n_win)
    );

    assign o_in_stall              = (r_state != S_IDLE);
    assign o_out_valid             = r_out_valid;
    assign o_outcome               = r_out_outcome;
    assign o_copy_position         = r_out_copy;
    assign o_prefetch_issue        = r_out_issue;
    assign o_prefetch_byte_address = r_out_addr;
    assign o_prefetch_bytes        = r_out_plen;

endmodule

// ===== sv/rwc_checker.sv =====
// ----------------------------------------------------------------------------
// Readahead window controller checker
// Port-level properties of the controller, attached by bind.
// ----------------------------------------------------------------------------
`include "readahead_window_controller_assert.svh"

module rwc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [rwc_pkg::TYPE_W-1:0]  i_req_type,
    input logic [rwc_pkg::LUN_W-1:0]   i_lun,
    input logic [rwc_pkg::SEC_W-1:0]   i_start_sector,
    input logic [rwc_pkg::BYTES_W-1:0] i_request_bytes,
    input logic [rwc_pkg::BYTES_W-1:0] i_fill_bytes,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_outcome,
    input logic [rwc_pkg::COPY_W-1:0]  o_copy_position,
    input logic                        o_prefetch_issue,
    input logic [rwc_pkg::ADDR_W-1:0]  o_prefetch_byte_address,
    input logic [rwc_pkg::BYTES_W-1:0] o_prefetch_bytes
);

    // A stalled result item stays offered with its outcome unchanged.
    `RWC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_outcome), "result item dropped or changed while stalled")

    // The block works on one item at a time.
    `RWC_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "new item taken while one is in work")

    // A miss always starts a prefetch.
    `RWC_ASSERT_IMP(a_miss_issues, o_out_valid && (o_outcome == rwc_pkg::OUT_MISS), o_prefetch_issue, "miss without prefetch")

    // Without a prefetch the fill address and length read zero.
    `RWC_ASSERT_IMP(a_no_issue_quiet, o_out_valid && !o_prefetch_issue, (o_prefetch_byte_address == '0) && (o_prefetch_bytes == '0), "prefetch fields set without issue")

    // Only a hit carries a copy position.
    `RWC_ASSERT_IMP(a_copy_only_hit, o_out_valid && (o_outcome != rwc_pkg::OUT_HIT), o_copy_position == '0, "copy position set on a non-hit")

endmodule

bind readahead_window_controller rwc_checker u_rwc_checker (.*);
